// ===== hdl/cftb_pkg.sv =====
// Shared constants, operation codes and request types for the channel timer bank.
// Used by every module in the hdl folder; depends on nothing else.
package cftb_pkg;

    // Bank size
    localparam int CHANNELS = 16;
    localparam int KINDS    = 16;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KIND_AW  = (KINDS > 1) ? $clog2(KINDS) : 1;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int CHAN_W  = 4;
    localparam int KIND_W  = 4;
    localparam int CNT_W   = 32;
    localparam int ACC_W   = 32;
    localparam int DELTA_W = 16;
    localparam int PER_W   = 16;
    localparam int WRAP_W  = 16;

    // Operation codes carried in the request tuser
    localparam logic [MODE_W-1:0] OP_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] OP_CLEAR    = 3'd1;
    localparam logic [MODE_W-1:0] OP_ALLOC    = 3'd2;
    localparam logic [MODE_W-1:0] OP_ENABLE   = 3'd3;
    localparam logic [MODE_W-1:0] OP_DISABLE  = 3'd4;
    localparam logic [MODE_W-1:0] OP_SET      = 3'd5;
    localparam logic [MODE_W-1:0] OP_READ     = 3'd6;
    localparam logic [MODE_W-1:0] OP_LOAD     = 3'd7;

    // Bits of one modulo pass, one per cycle
    localparam int MOD_STEPS = CNT_W;
    localparam int MOD_CW    = $clog2(MOD_STEPS);

    // Channel state memory access
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic             clr;
        logic [CH_AW-1:0] addr;
        logic [CNT_W-1:0] wr_cnt;
        logic [ACC_W-1:0] wr_acc;
    } t_store_req;

    // Kind table access
    typedef struct packed {
        logic               rd_en;
        logic [KIND_AW-1:0] rd_addr;
        logic               wr_en;
        logic [KIND_AW-1:0] wr_addr;
        logic [PER_W-1:0]   wr_per;
        logic [WRAP_W-1:0]  wr_wrap;
    } t_kind_req;

    // Modulo unit start and result
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  dividend;
        logic [WRAP_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [WRAP_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ===== hdl/cftb_mod.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a nonzero 16-bit divisor.
// Depends on cftb_pkg for widths and the request/response types.
module cftb_mod import cftb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [MOD_CW-1:0] r_step;
    logic [CNT_W-1:0]  r_dvd;
    logic [WRAP_W-1:0] r_div;
    logic [WRAP_W-1:0] r_rem;

    logic [WRAP_W:0]   trial;
    logic [WRAP_W:0]   diff;
    logic [WRAP_W-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[CNT_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[WRAP_W-1:0];
        end else begin
            n_rem = trial[WRAP_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == MOD_CW'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CNT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hdl/cftb_kind_tbl.sv =====
// Kind table: period and wrap count per kind, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on cftb_pkg.
module cftb_kind_tbl import cftb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kind_req         i_req,
    output logic [PER_W-1:0]  o_per,
    output logic [WRAP_W-1:0] o_wrap
);

    logic [PER_W+WRAP_W-1:0] r_mem [KINDS];
    logic [KINDS-1:0]        r_vld;
    logic [PER_W+WRAP_W-1:0] r_rd_data;
    logic                    r_rd_vld;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_per, i_req.wr_wrap};
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_per  = r_rd_vld ? r_rd_data[PER_W+WRAP_W-1:WRAP_W] : '0;
    assign o_wrap = r_rd_vld ? r_rd_data[WRAP_W-1:0] : '0;

endmodule

// ===== hdl/cftb_chan_store.sv =====
// Channel state memory: counter and accumulator per channel, registered read.
// Valid bits give the zero reset value and clear the whole bank at once.
// Depends on cftb_pkg.
module cftb_chan_store import cftb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_req       i_req,
    output logic [CNT_W-1:0] o_cnt,
    output logic [ACC_W-1:0] o_acc
);

    logic [CNT_W+ACC_W-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0]    r_vld;
    logic [CNT_W+ACC_W-1:0] r_rd_data;
    logic                   r_rd_vld;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= {i_req.wr_cnt, i_req.wr_acc};
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // Valid bits; clear invalidates every entry at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_cnt = r_rd_vld ? r_rd_data[CNT_W+ACC_W-1:ACC_W] : '0;
    assign o_acc = r_rd_vld ? r_rd_data[ACC_W-1:0] : '0;

endmodule

// ===== hdl/channel_frame_timer_bank.sv =====
// Channel timer bank top level: request sequencer, channel flags and result register.
// Depends on cftb_pkg, cftb_chan_store, cftb_kind_tbl and cftb_mod.
//
// Usage:
//   Requests enter on the s-side stream; tuser holds the operation code, tdata
//   the channel, kind, value, delta, period and wrap count. Every request gives
//   exactly one result on the m-side stream: tuser is the ok flag, tdata the
//   counter read back (zero for every operation but read counter).
//   One request is worked on at a time. Clear, enable, disable, load kind and a
//   failed allocate, set counter or read counter go from execute straight to
//   done; a successful allocate, set counter or read counter also passes the
//   evaluate state, since it goes through the channel memory read port.
//   A tick walks every channel in turn through the channel memory: a channel
//   that is not running is only looked at in the read state; a running channel
//   is read, evaluated and written back, and waits on the bit-serial remainder
//   unit in between when its counter wraps. The memory read-modify-write sets
//   the time per running channel, the remainder unit the worst case.
//   Reset clears all flags and kinds directly, and counters, accumulators and
//   the kind table at once through valid bits; no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register; the
//   next request is accepted at once, and its result waits behind the first.
module channel_frame_timer_bank import cftb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] channel, [7:4] kind, [39:8] value, [55:40] delta,
    // [71:56] period_entry, [87:72] count_entry
    input  logic [87:0] i_s_tdata,
    // [2:0] mode
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] counter_value
    output logic [31:0] o_m_tdata,
    // [0] ok
    output logic [0:0]  o_m_tuser
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXEC  = 4'd1;
    localparam logic [3:0] ST_CEVAL = 4'd2;
    localparam logic [3:0] ST_TRD   = 4'd3;
    localparam logic [3:0] ST_TEVAL = 4'd4;
    localparam logic [3:0] ST_TDIV  = 4'd5;
    localparam logic [3:0] ST_TWR   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    // Latched request
    logic [MODE_W-1:0]  r_mode;
    logic [CHAN_W-1:0]  r_ch;
    logic [KIND_W-1:0]  r_kind_in;
    logic [CNT_W-1:0]   r_value;
    logic [DELTA_W-1:0] r_delta;
    logic [PER_W-1:0]   r_per_in;
    logic [WRAP_W-1:0]  r_wrap_in;

    // Channel flags and kinds
    logic [CHANNELS-1:0] r_active;
    logic [CHANNELS-1:0] r_enabled;
    logic [KIND_W-1:0]   r_chkind [CHANNELS];

    // Tick walk
    logic [CH_AW-1:0]   r_idx;
    logic               r_kok;
    logic [CNT_W-1:0]   r_cnt_n;
    logic [ACC_W-1:0]   r_acc_n;

    // Result
    logic               r_res_ok;
    logic [CNT_W-1:0]   r_res_rd;
    logic               r_out_vld;
    logic               r_out_ok;
    logic [CNT_W-1:0]   r_out_rd;

    t_store_req         st_req;
    t_kind_req          kt_req;
    t_mod_req           mod_req;
    t_mod_rsp           mod_rsp;
    logic [CNT_W-1:0]   st_cnt;
    logic [ACC_W-1:0]   st_acc;
    logic [PER_W-1:0]   kt_per;
    logic [WRAP_W-1:0]  kt_wrap;

    logic               s_acc;
    logic               out_free;
    logic [7:0]         ch_ext;
    logic               ch_ok;
    logic [CH_AW-1:0]   ch_addr;
    logic [4:0]         kin_ext;
    logic               kin_ok;
    logic [CH_AW-1:0]   f_idx;
    logic               f_run;
    logic [KIND_W-1:0]  f_kind;
    logic               f_kok;
    logic               last_ch;
    logic               ch_op_go;
    logic [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   per32;
    logic [WRAP_W-1:0]  wrap16;
    logic               hit;
    logic [CNT_W-1:0]   cinc;
    logic               need_mod;

    // Request decode
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_vld || i_m_tready;
    assign ch_ext   = {4'b0, r_ch};
    assign ch_ok    = ch_ext < 8'(CHANNELS);
    assign ch_addr  = ch_ext[CH_AW-1:0];
    assign kin_ext  = {1'b0, r_kind_in};
    assign kin_ok   = kin_ext < 5'(KINDS);
    assign last_ch  = r_idx == CH_AW'(CHANNELS - 1);

    // Flag lookup at the walk index in the tick read state, else at the addressed channel
    assign f_idx  = (r_state == ST_TRD) ? r_idx : ch_addr;
    assign f_run  = r_active[f_idx] && r_enabled[f_idx];
    assign f_kind = r_chkind[f_idx];
    assign f_kok  = {1'b0, f_kind} < 5'(KINDS);

    assign ch_op_go = ch_ok && (((r_mode == OP_ALLOC) && !r_active[f_idx])
                             || (r_mode == OP_SET) || (r_mode == OP_READ));

    // Tick evaluation of one channel
    always_comb begin
        per32    = r_kok ? {16'b0, kt_per} : '0;
        wrap16   = r_kok ? kt_wrap : '0;
        acc_sum  = st_acc + {16'b0, r_delta};
        hit      = acc_sum >= per32;
        cinc     = st_cnt + 1'b1;
        need_mod = hit && (wrap16 != '0) && (cinc >= {16'b0, wrap16});
    end

    // Channel memory requests
    always_comb begin
        st_req.rd_en  = ((r_state == ST_EXEC) && ch_op_go)
                     || ((r_state == ST_TRD) && f_run);
        st_req.wr_en  = ((r_state == ST_CEVAL) && (r_mode != OP_READ))
                     || (r_state == ST_TWR);
        st_req.clr    = (r_state == ST_EXEC) && (r_mode == OP_CLEAR);
        st_req.addr   = ((r_state == ST_TRD) || (r_state == ST_TWR)) ? r_idx : ch_addr;
        st_req.wr_cnt = (r_state == ST_TWR) ? r_cnt_n
                      : ((r_mode == OP_SET) ? r_value : '0);
        st_req.wr_acc = (r_state == ST_TWR) ? r_acc_n : st_acc;
    end

    // Kind table requests
    always_comb begin
        kt_req.rd_en   = (r_state == ST_TRD) && f_run && f_kok;
        kt_req.rd_addr = f_kind[KIND_AW-1:0];
        kt_req.wr_en   = (r_state == ST_EXEC) && (r_mode == OP_LOAD) && kin_ok;
        kt_req.wr_addr = r_kind_in[KIND_AW-1:0];
        kt_req.wr_per  = r_per_in;
        kt_req.wr_wrap = r_wrap_in;
    end

    // Remainder unit start
    always_comb begin
        mod_req.start    = (r_state == ST_TEVAL) && need_mod;
        mod_req.dividend = cinc;
        mod_req.divisor  = wrap16;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_mode == OP_TICK) begin
                    n_state = ST_TRD;
                end else if (ch_op_go) begin
                    n_state = ST_CEVAL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CEVAL: n_state = ST_DONE;
            ST_TRD: begin
                if (f_run) begin
                    n_state = ST_TEVAL;
                end else if (last_ch) begin
                    n_state = ST_DONE;
                end
            end
            ST_TEVAL: n_state = need_mod ? ST_TDIV : ST_TWR;
            ST_TDIV: begin
                if (mod_rsp.done) n_state = ST_TWR;
            end
            ST_TWR:  n_state = last_ch ? ST_DONE : ST_TRD;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= '0;
            r_enabled <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_chkind[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                case (r_mode)
                    OP_CLEAR: r_active <= '0;
                    OP_ALLOC: begin
                        if (ch_op_go) begin
                            r_active[ch_addr]  <= 1'b1;
                            r_enabled[ch_addr] <= 1'b0;
                            r_chkind[ch_addr]  <= r_kind_in;
                        end
                    end
                    OP_ENABLE, OP_DISABLE: begin
                        if (ch_ok) r_enabled[ch_addr] <= (r_mode == OP_ENABLE);
                    end
                    default: ;
                endcase
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request, walk and result payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode    <= i_s_tuser;
            r_ch      <= i_s_tdata[3:0];
            r_kind_in <= i_s_tdata[7:4];
            r_value   <= i_s_tdata[39:8];
            r_delta   <= i_s_tdata[55:40];
            r_per_in  <= i_s_tdata[71:56];
            r_wrap_in <= i_s_tdata[87:72];
        end
        case (r_state)
            ST_EXEC: begin
                r_idx    <= '0;
                r_res_rd <= '0;
                case (r_mode)
                    OP_ALLOC:                    r_res_ok <= ch_op_go;
                    OP_ENABLE, OP_DISABLE,
                    OP_SET, OP_READ:             r_res_ok <= ch_ok;
                    OP_LOAD:                     r_res_ok <= kin_ok;
                    default:                     r_res_ok <= 1'b1;
                endcase
            end
            ST_CEVAL: begin
                if (r_mode == OP_READ) r_res_rd <= st_cnt;
            end
            ST_TRD: begin
                r_kok <= f_kok;
                if (!f_run && !last_ch) r_idx <= r_idx + 1'b1;
            end
            ST_TEVAL: begin
                r_acc_n <= hit ? (acc_sum - per32) : acc_sum;
                r_cnt_n <= hit ? cinc : st_cnt;
            end
            ST_TDIV: begin
                if (mod_rsp.done) r_cnt_n <= {16'b0, mod_rsp.rem};
            end
            ST_TWR: begin
                if (!last_ch) r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
        if ((r_state == ST_DONE) && out_free) begin
            r_out_ok <= r_res_ok;
            r_out_rd <= r_res_rd;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_rd;
    assign o_m_tuser  = r_out_ok;

    cftb_chan_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_cnt   (st_cnt),
        .o_acc   (st_acc)
    );

    cftb_kind_tbl u_kind (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (kt_req),
        .o_per   (kt_per),
        .o_wrap  (kt_wrap)
    );

    cftb_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

`ifndef SYNTHESIS
    // The channel memory never sees a read and a write in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_req.rd_en && st_req.wr_en))
        else $error("channel memory read and write overlap");

    // A wrap remainder is only started while a channel is being evaluated
    a_mod_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |=> (r_state == ST_TDIV))
        else $error("remainder started outside a tick evaluation");

    // The walk index stays inside the bank
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TRD) || (r_state == ST_TWR)) |-> ({4'b0, r_idx} < 8'(CHANNELS)))
        else $error("tick walk index out of range");

    // An accepted request is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");
`endif

endmodule

// ===== sim/channel_frame_timer_bank_test.sv =====
// Testbench for channel_frame_timer_bank: directed corner cases, then random timer traffic.
// Depends on cftb_pkg and the channel_frame_timer_bank RTL; self-checking against its own model.
`timescale 1ns / 1ps

module channel_frame_timer_bank_test;
    import cftb_pkg::*;

    localparam int RANDOM_REQS = 1575;
    localparam int SETTLE_CYCLES = 2 + 36 * CHANNELS + 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // [3:0] channel, [7:4] kind, [39:8] value, [55:40] delta,
    // [71:56] period_entry, [87:72] count_entry
    logic [87:0] i_s_tdata;
    // [2:0] mode
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [31:0] counter_value
    logic [31:0] o_m_tdata;
    // [0] ok
    logic [0:0]  o_m_tuser;

    // One expected response
    typedef struct {
        logic        ok;
        logic [31:0] counter_value;
    } t_timer_rsp;

    t_timer_rsp pending_rsps[$];

    // Shadow copy of the bank
    logic              shadow_active [CHANNELS];
    logic              shadow_enabled[CHANNELS];
    logic [KIND_W-1:0] shadow_kind   [CHANNELS];
    logic [CNT_W-1:0]  shadow_counter[CHANNELS];
    logic [ACC_W-1:0]  shadow_acc    [CHANNELS];
    logic [PER_W-1:0]  shadow_period [KINDS];
    logic [WRAP_W-1:0] shadow_wrap   [KINDS];

    int  mismatch_count = 0;
    int  reqs_sent = 0;
    int  rsps_checked = 0;
    int  ticks_sent = 0;
    bit  steady_flow = 1'b0;

    channel_frame_timer_bank DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Run limit, well above the slowest legal run
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Advance the shadow bank by one request and return what it should answer
    task automatic timer_bank_step(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                                   input logic [KIND_W-1:0] knd, input logic [CNT_W-1:0] val,
                                   input logic [DELTA_W-1:0] dlt, input logic [PER_W-1:0] per,
                                   input logic [WRAP_W-1:0] wrap, output t_timer_rsp rsp);
        logic [PER_W-1:0]  ch_per;
        logic [WRAP_W-1:0] ch_wrap;
        bit                chan_ok;
        chan_ok = (int'(chan) < CHANNELS);
        rsp.ok = 1'b1;
        rsp.counter_value = '0;
        case (mode)
            OP_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (shadow_active[c] && shadow_enabled[c]) begin
                        ch_per = '0;
                        ch_wrap = '0;
                        // Kinds beyond the table behave as period 0, no wrap
                        if (int'(shadow_kind[c]) < KINDS) begin
                            ch_per = shadow_period[shadow_kind[c]];
                            ch_wrap = shadow_wrap[shadow_kind[c]];
                        end
                        shadow_acc[c] = shadow_acc[c] + dlt;
                        if (shadow_acc[c] >= ch_per) begin
                            shadow_acc[c] = shadow_acc[c] - ch_per;
                            shadow_counter[c] = shadow_counter[c] + 1;
                            if (ch_wrap != 0)
                                shadow_counter[c] = shadow_counter[c] % ch_wrap;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                // enabled flags and kinds survive a clear
                for (int c = 0; c < CHANNELS; c++) begin
                    shadow_active[c] = 1'b0;
                    shadow_counter[c] = '0;
                    shadow_acc[c] = '0;
                end
            end
            OP_ALLOC: begin
                if (!chan_ok || shadow_active[chan]) begin
                    rsp.ok = 1'b0;
                end else begin
                    shadow_active[chan] = 1'b1;
                    shadow_enabled[chan] = 1'b0;
                    shadow_kind[chan] = knd;
                    shadow_counter[chan] = '0;
                end
            end
            OP_ENABLE, OP_DISABLE: begin
                if (!chan_ok)
                    rsp.ok = 1'b0;
                else
                    shadow_enabled[chan] = (mode == OP_ENABLE);
            end
            OP_SET: begin
                if (!chan_ok)
                    rsp.ok = 1'b0;
                else
                    shadow_counter[chan] = val;
            end
            OP_READ: begin
                if (!chan_ok)
                    rsp.ok = 1'b0;
                else
                    rsp.counter_value = shadow_counter[chan];
            end
            default: begin
                if (int'(knd) >= KINDS) begin
                    rsp.ok = 1'b0;
                end else begin
                    shadow_period[knd] = per;
                    shadow_wrap[knd] = wrap;
                end
            end
        endcase
    endtask

    // Send one request, with random idle cycles ahead of it unless the flow is steady
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                            input logic [KIND_W-1:0] knd, input logic [CNT_W-1:0] val,
                            input logic [DELTA_W-1:0] dlt, input logic [PER_W-1:0] per,
                            input logic [WRAP_W-1:0] wrap);
        t_timer_rsp rsp;
        if (!steady_flow) begin
            while ($urandom_range(99) < 22) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {wrap, per, dlt, val, knd, chan};
        do @(posedge i_clk); while (!o_s_tready);
        timer_bank_step(mode, chan, knd, val, dlt, per, wrap, rsp);
        pending_rsps.push_back(rsp);
        reqs_sent++;
        if (mode == OP_TICK)
            ticks_sent++;
    endtask

    // Response checker
    always @(posedge i_clk) begin
        t_timer_rsp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rsps_checked++;
            if (pending_rsps.size() == 0) begin
                $error("response with nothing pending: ok=%0d counter_value=%h",
                       o_m_tuser[0], o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_rsps.pop_front();
                if (o_m_tuser[0] !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_m_tuser[0]);
                    mismatch_count++;
                end
                if (o_m_tdata !== want.counter_value) begin
                    $error("counter_value: expected %h, got %h", want.counter_value, o_m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= steady_flow || ($urandom_range(99) >= 22);
    end

    task automatic test_after_reset();
        send_req(OP_READ, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_TICK, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0);
    endtask

    task automatic test_kind_load();
        send_req(OP_LOAD, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_LOAD, 4'd0, 4'd15, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_req(OP_LOAD, 4'd0, 4'd3, 32'd0, 16'd0, 16'd3, 16'd5);
    endtask

    // Second allocate of an active channel must fail
    task automatic test_allocate();
        send_req(OP_ALLOC, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_ALLOC, 4'd0, 4'd3, 32'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // Period zero: counter steps every tick and rolls over at the top
    task automatic test_period_zero();
        send_req(OP_ENABLE, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_SET, 4'd0, 4'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
        send_req(OP_TICK, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_READ, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // Counter reduced by the kind's wrap count
    task automatic test_wrap_count();
        send_req(OP_ALLOC, 4'd15, 4'd3, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_ENABLE, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_SET, 4'd15, 4'd0, 32'd4, 16'd0, 16'd0, 16'd0);
        send_req(OP_TICK, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0);
        send_req(OP_READ, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // Enable and disable still apply to a channel that is not allocated
    task automatic test_inactive_flags();
        send_req(OP_DISABLE, 4'd7, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_ENABLE, 4'd7, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // Clear, then reallocate: accumulator from before allocate carries over
    task automatic test_clear_all();
        send_req(OP_TICK, 4'd0, 4'd0, 32'd0, 16'h1234, 16'd0, 16'd0);
        send_req(OP_CLEAR, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_READ, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_ALLOC, 4'd15, 4'd15, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_ENABLE, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        send_req(OP_TICK, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0);
        send_req(OP_READ, 4'd15, 4'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // Random traffic: mostly ticks and reads over random channels and kinds
    task automatic test_random_traffic();
        logic [MODE_W-1:0]  mode;
        logic [DELTA_W-1:0] dlt;
        logic [PER_W-1:0]   per;
        logic [WRAP_W-1:0]  wrap;
        int                 pick;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady_flow = (n >= 500 && n < 800);
            pick = $urandom_range(199);
            if (pick < 70)       mode = OP_TICK;
            else if (pick < 110) mode = OP_READ;
            else if (pick < 130) mode = OP_ALLOC;
            else if (pick < 150) mode = OP_ENABLE;
            else if (pick < 160) mode = OP_DISABLE;
            else if (pick < 175) mode = OP_SET;
            else if (pick < 197) mode = OP_LOAD;
            else                 mode = OP_CLEAR;
            // small deltas and periods keep counters moving; full range now and then
            dlt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
            per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
            case ($urandom_range(7))
                0, 1:    wrap = '0;
                7:       wrap = 16'($urandom);
                default: wrap = 16'($urandom_range(1, 12));
            endcase
            send_req(mode, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom,
                     dlt, per, wrap);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= OP_TICK;
        for (int c = 0; c < CHANNELS; c++) begin
            shadow_active[c] = 1'b0;
            shadow_enabled[c] = 1'b0;
            shadow_kind[c] = '0;
            shadow_counter[c] = '0;
            shadow_acc[c] = '0;
        end
        for (int k = 0; k < KINDS; k++) begin
            shadow_period[k] = '0;
            shadow_wrap[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_kind_load();
        test_allocate();
        test_period_zero();
        test_wrap_count();
        test_inactive_flags();
        test_clear_all();
        test_random_traffic();

        // Drain outstanding responses, then watch for strays
        i_s_tvalid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d ticks), checked %0d responses", reqs_sent,
                 ticks_sent, rsps_checked);
        $display("Covered allocate, enable, counter set, read, wrap, clear and kind load");
        if (mismatch_count == 0 && pending_rsps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
